// File: rtl/dirnd_pkg.sv
// shared types and constants of the decimal integer rounding unit
`timescale 1ns / 1ps
`default_nettype none

package dirnd_pkg;

  // field widths of one transaction
  localparam int OP_W    = 2;
  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 32;
  localparam int SCALE_W = 5;
  localparam int FULL_W  = LOW_W + HIGH_W;

  // the divider works on one limb per cycle
  localparam int LIMB_W  = 32;
  localparam int DIGIT_W = 4;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_NEGATE   = 2'd0,
    OP_TRUNCATE = 2'd1,
    OP_FLOOR    = 2'd2,
    OP_ROUND    = 2'd3
  } op_e;

  // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) equals x / 10 for any 32-bit x
  localparam logic [LIMB_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;
  // 2^32 = 10 * LIMB_TEN_Q + LIMB_TEN_R
  localparam logic [LIMB_W-1:0] LIMB_TEN_Q  = 32'd429496729;
  localparam logic [2:0]        LIMB_TEN_R  = 3'd6;
  // floor(t * 13 / 128) equals t / 10 for t below 64
  localparam logic [3:0]        SMALL_RECIP = 4'd13;
  localparam int                SMALL_SHIFT = 7;
  localparam logic [DIGIT_W-1:0] TEN        = 4'd10;
  localparam logic [DIGIT_W-1:0] HALF_DIGIT = 4'd5;

endpackage

`default_nettype wire

// File: rtl/dirnd_in_if.sv
// input channel of the decimal integer rounding unit
`timescale 1ns / 1ps
`default_nettype none

interface dirnd_in_if;
  import dirnd_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [LOW_W-1:0]   mantissa_low;
  logic [HIGH_W-1:0]  mantissa_high;
  logic [SCALE_W-1:0] scale;
  logic               negative;

  modport source (
    output valid, operation, mantissa_low, mantissa_high, scale, negative,
    input  ready
  );

  modport sink (
    input  valid, operation, mantissa_low, mantissa_high, scale, negative,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/dirnd_out_if.sv
// output channel of the decimal integer rounding unit
`timescale 1ns / 1ps
`default_nettype none

interface dirnd_out_if;
  import dirnd_pkg::*;

  logic               valid;
  logic               ready;
  logic [LOW_W-1:0]   result_mantissa_low;
  logic [HIGH_W-1:0]  result_mantissa_high;
  logic [SCALE_W-1:0] result_scale;
  logic               result_negative;

  modport source (
    output valid, result_mantissa_low, result_mantissa_high, result_scale,
           result_negative,
    input  ready
  );

  modport sink (
    input  valid, result_mantissa_low, result_mantissa_high, result_scale,
           result_negative,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/decimal_integer_rounding_unit.sv
// top level of the decimal integer rounding unit: sequencer, magnitude register, output stage
//
//   channel | dir | handshake         | payload
//   in_i    | in  | valid / ready     | operation, mantissa_low/high, scale, negative
//   out_o   | out | valid / ready     | result_mantissa_low/high, result_scale, result_negative
//
// truncate, floor and round run scale divide-by-ten steps of LIMBS limbs each (LIMBS = ceil(MANTISSA_BITS/32)),
// on the shared limb divider that does one 32-bit limb of a divide by ten per cycle;
// negate and scale zero skip the divider and go from accept straight to the fix-up state.
// in_i.ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer holds its result until that register is free.
// reset clears the sequencer and the output valid flag; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module decimal_integer_rounding_unit #(
  parameter int MANTISSA_BITS = 96,
  parameter int MAX_SCALE     = 28
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dirnd_in_if.sink    in_i,
  dirnd_out_if.source out_o
);
  import dirnd_pkg::*;

  localparam int LIMBS = (MANTISSA_BITS + LIMB_W - 1) / LIMB_W;
  localparam int MAG_W = LIMBS * LIMB_W;
  localparam int IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(LIMBS - 1);
  localparam logic [SCALE_W-1:0] SCALE_CAP = SCALE_W'(MAX_SCALE);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [DIGIT_W-1:0] first_q, first_d;
  logic               sticky_q, sticky_d;
  logic [SCALE_W-1:0] step_q, step_d;
  logic [SCALE_W-1:0] steps_q, steps_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic               neg_q, neg_d;
  logic [SCALE_W-1:0] scale_q, scale_d;

  logic               out_valid_q, out_valid_d;
  logic [FULL_W-1:0]  out_mag_q, out_mag_d;
  logic [SCALE_W-1:0] out_scale_q, out_scale_d;
  logic               out_neg_q, out_neg_d;

  logic [FULL_W-1:0]  in_full;
  logic [MAG_W-1:0]   in_mag;
  logic [SCALE_W-1:0] in_steps;
  logic [LIMB_W-1:0]  div_limb;
  logic [DIGIT_W-1:0] div_rem_in;
  logic [LIMB_W-1:0]  div_quot;
  logic [DIGIT_W-1:0] div_rem_out;
  logic               round_up;
  logic [MAG_W-1:0]   mag_fix;
  logic               out_free;

  // input magnitude cut to the configured width
  assign in_full  = {in_i.mantissa_high, in_i.mantissa_low};
  assign in_mag   = MAG_W'(in_full[MANTISSA_BITS-1:0]);
  assign in_steps = (in_i.scale > SCALE_CAP) ? SCALE_CAP : in_i.scale;

  // shared divider on the current limb
  assign div_limb   = mag_q[idx_q*LIMB_W +: LIMB_W];
  assign div_rem_in = (idx_q == LAST_IDX) ? '0 : rem_q;

  dirnd_div10 u_div10 (
    .limb_i (div_limb),
    .rem_i  (div_rem_in),
    .quot_o (div_quot),
    .rem_o  (div_rem_out)
  );

  // increment decision
  always_comb begin
    case (op_e'(op_q))
      OP_FLOOR: round_up = neg_q && ((first_q != '0) || sticky_q);
      OP_ROUND: round_up = (first_q > HALF_DIGIT) ||
                           ((first_q == HALF_DIGIT) && (sticky_q || mag_q[0]));
      default:  round_up = 1'b0;
    endcase
  end

  assign mag_fix  = mag_q + MAG_W'(round_up);
  assign out_free = !out_valid_q || out_o.ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    first_d     = first_q;
    sticky_d    = sticky_q;
    step_d      = step_q;
    steps_d     = steps_q;
    op_d        = op_q;
    neg_d       = neg_q;
    scale_d     = scale_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_mag_d   = out_mag_q;
    out_scale_d = out_scale_q;
    out_neg_d   = out_neg_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mag_d    = in_mag;
          idx_d    = LAST_IDX;
          rem_d    = '0;
          first_d  = '0;
          sticky_d = 1'b0;
          step_d   = '0;
          steps_d  = in_steps;
          op_d     = in_i.operation;
          neg_d    = in_i.negative;
          scale_d  = in_i.scale;
          if ((op_e'(in_i.operation) == OP_NEGATE) || (in_steps == '0)) begin
            state_d = ST_FIX;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_d[idx_q*LIMB_W +: LIMB_W] = div_quot;
        rem_d = div_rem_out;
        if (idx_q == LAST_IDX) begin
          sticky_d = sticky_q || (first_q != '0);
        end
        if (idx_q == '0) begin
          first_d = div_rem_out;
          idx_d   = LAST_IDX;
          step_d  = step_q + 1'b1;
          if (step_d == steps_q) begin
            state_d = ST_FIX;
          end
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mag_d   = FULL_W'(mag_fix[MANTISSA_BITS-1:0]);
          if (op_e'(op_q) == OP_NEGATE) begin
            out_scale_d = scale_q;
            out_neg_d   = !neg_q;
          end else begin
            out_scale_d = '0;
            out_neg_d   = neg_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    idx_q       <= idx_d;
    rem_q       <= rem_d;
    first_q     <= first_d;
    sticky_q    <= sticky_d;
    step_q      <= step_d;
    steps_q     <= steps_d;
    op_q        <= op_d;
    neg_q       <= neg_d;
    scale_q     <= scale_d;
    out_mag_q   <= out_mag_d;
    out_scale_q <= out_scale_d;
    out_neg_q   <= out_neg_d;
  end

  // channel outputs
  assign in_i.ready                 = (state_q == ST_IDLE);
  assign out_o.valid                = out_valid_q;
  assign out_o.result_mantissa_low  = out_mag_q[LOW_W-1:0];
  assign out_o.result_mantissa_high = out_mag_q[FULL_W-1:LOW_W];
  assign out_o.result_scale         = out_scale_q;
  assign out_o.result_negative      = out_neg_q;

endmodule

`default_nettype wire

// File: rtl/dirnd_div10.sv
// one limb step of a long division by ten
`timescale 1ns / 1ps
`default_nettype none

module dirnd_div10 (
  input  wire logic [dirnd_pkg::LIMB_W-1:0]  limb_i,
  input  wire logic [dirnd_pkg::DIGIT_W-1:0] rem_i,
  output logic      [dirnd_pkg::LIMB_W-1:0]  quot_o,
  output logic      [dirnd_pkg::DIGIT_W-1:0] rem_o
);
  import dirnd_pkg::*;

  logic [2*LIMB_W-1:0] prod;
  logic [LIMB_W-1:0]   limb_q10;
  logic [LIMB_W-1:0]   limb_back;
  logic [DIGIT_W-1:0]  limb_r10;
  logic [5:0]          tail;
  logic [9:0]          tail_prod;
  logic [DIGIT_W-1:0]  tail_q;
  logic [5:0]          tail_back;
  logic [LIMB_W-1:0]   upper_q;

  // limb / 10 through the reciprocal, remainder by shift-add back
  assign prod      = {{LIMB_W{1'b0}}, limb_i} * {{LIMB_W{1'b0}}, RECIP_TEN};
  assign limb_q10  = LIMB_W'(prod[2*LIMB_W-1:RECIP_SHIFT]);
  assign limb_back = (limb_q10 << 3) + (limb_q10 << 1);
  assign limb_r10  = DIGIT_W'(limb_i - limb_back);

  // carried remainder times 2^32 splits into rem*LIMB_TEN_Q and rem*6
  assign tail      = 6'(rem_i) * 6'(LIMB_TEN_R) + 6'(limb_r10);
  assign tail_prod = 10'(tail) * 10'(SMALL_RECIP);
  assign tail_q    = DIGIT_W'(tail_prod >> SMALL_SHIFT);
  assign tail_back = 6'(tail_q) * 6'(TEN);
  assign upper_q   = LIMB_W'(rem_i) * LIMB_TEN_Q;

  assign quot_o = upper_q + limb_q10 + LIMB_W'(tail_q);
  assign rem_o  = DIGIT_W'(tail - tail_back);

endmodule

`default_nettype wire
